// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sound step sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SSS_ASSERT_IMP(name, a, b) \
   name: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("sss assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define SSS_ASSERT_NEXT(name, a, b) \
   name: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("sss assertion failed");

`endif

// ===== rtl/sss_pkg.sv =====
// Types, codes and constant tables of the sound step sequencer.
package sss_pkg;

   localparam int SOUND_SLOTS_DEF    = 4;
   localparam int STEP_ROM_DEPTH_DEF = 32;
   localparam int DEFINED_SOUNDS     = 4;
   localparam int ROM_AW             = 8;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   localparam logic [1:0] KIND_TONE  = 2'd0;
   localparam logic [1:0] KIND_VOL   = 2'd1;
   localparam logic [1:0] KIND_NOISE = 2'd2;

   localparam logic [1:0] NOISE_CHANNEL = 2'd3;
   localparam logic [3:0] SILENT        = 4'd15;

   typedef struct packed {
      logic [9:0] tone;
      logic [3:0] vol;
      logic [7:0] hold;
   } step_type;

   typedef struct packed {
      logic [4:0] start;
      logic [3:0] len;
      logic [1:0] chan;
      logic       noise;
   } info_type;

   typedef struct packed {
      logic       active;
      logic [3:0] pos;
      logic [7:0] hold;
   } slot_type;

   typedef struct packed {
      logic [1:0] chan;
      logic [1:0] kind;
      logic [9:0] value;
   } write_type;

   typedef struct packed {
      logic      push;
      logic      flush;
      write_type wr;
   } emit_req_type;

   function automatic step_type step_rom_f(input logic [ROM_AW-1:0] addr);
      step_type s;
      case (addr)
         8'd0:    s = '{10'd80,  4'd2,  8'd2};
         8'd1:    s = '{10'd140, 4'd5,  8'd2};
         8'd2:    s = '{10'd220, 4'd10, 8'd2};
         8'd3:    s = '{10'd600, 4'd3,  8'd4};
         8'd4:    s = '{10'd450, 4'd2,  8'd4};
         8'd5:    s = '{10'd300, 4'd1,  8'd4};
         8'd6:    s = '{10'd200, 4'd0,  8'd6};
         8'd7:    s = '{10'd0,   4'd0,  8'd3};
         8'd8:    s = '{10'd0,   4'd3,  8'd3};
         8'd9:    s = '{10'd0,   4'd6,  8'd3};
         8'd10:   s = '{10'd0,   4'd9,  8'd4};
         8'd11:   s = '{10'd0,   4'd12, 8'd4};
         8'd12:   s = '{10'd0,   4'd15, 8'd1};
         8'd13:   s = '{10'd60,  4'd0,  8'd4};
         8'd14:   s = '{10'd90,  4'd1,  8'd4};
         8'd15:   s = '{10'd130, 4'd2,  8'd5};
         8'd16:   s = '{10'd180, 4'd4,  8'd5};
         8'd17:   s = '{10'd240, 4'd7,  8'd6};
         8'd18:   s = '{10'd320, 4'd10, 8'd6};
         8'd19:   s = '{10'd420, 4'd13, 8'd8};
         8'd20:   s = '{10'd550, 4'd15, 8'd4};
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic info_type sound_info_f(input logic [1:0] idx);
      info_type i;
      case (idx)
         2'd0:    i = '{5'd0,  4'd3, 2'd0, 1'b0};
         2'd1:    i = '{5'd3,  4'd4, 2'd1, 1'b0};
         2'd2:    i = '{5'd7,  4'd6, 2'd3, 1'b1};
         default: i = '{5'd13, 4'd8, 2'd2, 1'b0};
      endcase
      return i;
   endfunction

endpackage

// ===== rtl/sss_if.sv =====
// Valid/ready channel interfaces for command words and chip write words.
interface sss_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [1:0] sound_select;

   modport source (output valid, output opcode, output sound_select, input ready);
   modport sink   (input valid, input opcode, input sound_select, output ready);
endinterface

interface sss_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] psg_channel;
   logic [1:0] write_kind;
   logic [9:0] write_value;
   logic       last_of_run;

   modport source (output valid, output psg_channel, output write_kind,
                   output write_value, output last_of_run, input ready);
   modport sink   (input valid, input psg_channel, input write_kind,
                   input write_value, input last_of_run, output ready);
endinterface

// ===== rtl/sss_slot_mem.sv =====
// Per-slot state memory: one write and one registered read per cycle.
`include "assert_macros.svh"

module sss_slot_mem #(
   parameter int DEPTH = 4,
   parameter int AW    = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output sss_pkg::slot_type   rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  sss_pkg::slot_type   wr_data
);

   sss_pkg::slot_type mem_ff [DEPTH];
   sss_pkg::slot_type rd_data_ff;
   logic [DEPTH-1:0]  valid_ff;

   // entries never written since reset read as idle slots
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else if (valid_ff[rd_addr]) begin
            rd_data_ff <= mem_ff[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

   `SSS_ASSERT_NEXT(a_mem_forward, rd_en && wr_en && (rd_addr == wr_addr), rd_data == $past(wr_data))

endmodule

// ===== rtl/sss_emit.sv =====
// Write staging: holds one word back to tag the last of a run, then registers it out.
`include "assert_macros.svh"

module sss_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  sss_pkg::emit_req_type req,
   output logic                  ok,
   sss_rsp_if.source             rsp_ch
);

   logic                pend_v_ff, pend_v_in;
   sss_pkg::write_type  pend_ff, pend_in;
   logic                out_v_ff, out_v_in;
   sss_pkg::write_type  out_ff, out_in;
   logic                out_last_ff, out_last_in;
   logic                out_free;
   logic                can_go;

   assign out_free = !out_v_ff || rsp_ch.ready;
   assign can_go   = !pend_v_ff || out_free;
   assign ok       = (req.push || req.flush) && can_go;

   always_comb begin
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      out_v_in    = out_v_ff && !rsp_ch.ready;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      // move the held word out; it is last only when the run closes
      if (ok && pend_v_ff) begin
         out_v_in    = 1'b1;
         out_in      = pend_ff;
         out_last_in = req.flush;
      end
      if (ok && req.push) begin
         pend_v_in = 1'b1;
         pend_in   = req.wr;
      end else if (ok && req.flush) begin
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.psg_channel = out_ff.chan;
   assign rsp_ch.write_kind  = out_ff.kind;
   assign rsp_ch.write_value = out_ff.value;
   assign rsp_ch.last_of_run = out_last_ff;

   `SSS_ASSERT_NEXT(a_push_moves_held, ok && req.push && pend_v_ff, out_v_ff && !out_last_ff)
   `SSS_ASSERT_NEXT(a_flush_tags_last, ok && req.flush && pend_v_ff, out_v_ff && out_last_ff && !pend_v_ff)

endmodule

// ===== rtl/sss_ctrl.sv =====
// Command sequencer: walks the slots, reads and writes slot state, issues chip writes.
`include "assert_macros.svh"

module sss_ctrl #(
   parameter int LIVE_SLOTS = 4,
   parameter int LIVE_AW    = 2,
   parameter int STEP_ROM_DEPTH = 32,
   parameter int ROM_DAW    = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   sss_req_if.sink                req_ch,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_wr_data,
   output logic                   mem_rd_en,
   output logic [LIVE_AW-1:0]     mem_rd_addr,
   input  sss_pkg::slot_type      mem_rd_data,
   output logic                   mem_wr_en,
   output logic [LIVE_AW-1:0]     mem_wr_addr,
   output sss_pkg::slot_type      mem_wr_data,
   output sss_pkg::emit_req_type  emit_req,
   input  logic                   emit_ok
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_RD    = 3'd2;
   localparam logic [2:0] ST_EVAL  = 3'd3;
   localparam logic [2:0] ST_TONE  = 3'd4;
   localparam logic [2:0] ST_VOL   = 3'd5;
   localparam logic [2:0] ST_STOP  = 3'd6;
   localparam logic [2:0] ST_FLUSH = 3'd7;

   localparam logic [1:0] LAST_SLOT = 2'(LIVE_SLOTS - 1);

   logic [2:0]         state_ff, state_in;
   logic [1:0]         slot_ff, slot_in;
   logic [2:0]         noise_ff, noise_in;
   sss_pkg::step_type  rom_ff, rom_in;
   sss_pkg::info_type  info;
   sss_pkg::info_type  sel_info;
   sss_pkg::slot_type  cur;
   logic [8:0]         rom_sum;
   logic [ROM_DAW-1:0] rom_addr;
   sss_pkg::step_type  rom_data;
   logic               is_last;
   logic               start_ok;

   assign info     = sss_pkg::sound_info_f(slot_ff);
   assign sel_info = sss_pkg::sound_info_f(req_ch.sound_select);
   assign cur      = mem_rd_data;
   assign is_last  = (slot_ff == LAST_SLOT);
   assign start_ok = (3'(req_ch.sound_select) < 3'(LIVE_SLOTS));

   // step address past the end of the table reads as an all-zero step
   assign rom_sum  = 9'(info.start) + 9'(cur.pos);
   assign rom_addr = rom_sum[ROM_DAW-1:0];
   assign rom_data = (rom_sum < 9'(STEP_ROM_DEPTH)) ?
                     sss_pkg::step_rom_f(sss_pkg::ROM_AW'(rom_addr)) : '0;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      noise_in     = csr_wr_en ? csr_wr_data : noise_ff;
      rom_in       = rom_ff;
      req_ch.ready = (state_ff == ST_IDLE);
      mem_rd_en    = 1'b0;
      mem_rd_addr  = slot_ff[LIVE_AW-1:0];
      mem_wr_en    = 1'b0;
      mem_wr_addr  = slot_ff[LIVE_AW-1:0];
      mem_wr_data  = '0;
      emit_req     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               slot_in = '0;
               unique case (req_ch.opcode)
                  sss_pkg::OP_TICK: begin
                     state_in = ST_RD;
                  end
                  sss_pkg::OP_START: begin
                     state_in = ST_FLUSH;
                     if (start_ok) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = req_ch.sound_select[LIVE_AW-1:0];
                        mem_wr_data = '{active: 1'b1, pos: 4'd0, hold: 8'd0};
                        if (sel_info.noise) begin
                           state_in = ST_START;
                        end
                     end
                  end
                  sss_pkg::OP_STOP: begin
                     state_in = ST_STOP;
                  end
                  default: begin
                     state_in = ST_FLUSH;
                  end
               endcase
            end
         end
         ST_START: begin
            emit_req.push = 1'b1;
            emit_req.wr   = '{chan: sss_pkg::NOISE_CHANNEL, kind: sss_pkg::KIND_NOISE,
                              value: 10'(noise_ff)};
            if (emit_ok) begin
               state_in = ST_FLUSH;
            end
         end
         ST_RD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_EVAL;
         end
         ST_EVAL: begin
            if (!cur.active) begin
               state_in = is_last ? ST_FLUSH : ST_RD;
               slot_in  = slot_ff + 2'd1;
            end else if (cur.hold != 8'd0) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = '{active: 1'b1, pos: cur.pos, hold: cur.hold - 8'd1};
               state_in    = is_last ? ST_FLUSH : ST_RD;
               slot_in     = slot_ff + 2'd1;
            end else if (cur.pos >= info.len) begin
               emit_req.push = 1'b1;
               emit_req.wr   = '{chan: info.chan, kind: sss_pkg::KIND_VOL,
                                 value: 10'(sss_pkg::SILENT)};
               if (emit_ok) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = '{active: 1'b0, pos: cur.pos, hold: cur.hold};
                  state_in    = is_last ? ST_FLUSH : ST_RD;
                  slot_in     = slot_ff + 2'd1;
               end
            end else begin
               rom_in   = rom_data;
               state_in = ST_TONE;
            end
         end
         ST_TONE: begin
            if (info.noise) begin
               state_in = ST_VOL;
            end else begin
               emit_req.push = 1'b1;
               emit_req.wr   = '{chan: info.chan, kind: sss_pkg::KIND_TONE,
                                 value: rom_ff.tone};
               if (emit_ok) begin
                  state_in = ST_VOL;
               end
            end
         end
         ST_VOL: begin
            emit_req.push = 1'b1;
            emit_req.wr   = '{chan: info.chan, kind: sss_pkg::KIND_VOL,
                              value: 10'(rom_ff.vol)};
            if (emit_ok) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = '{active: 1'b1, pos: cur.pos + 4'd1, hold: rom_ff.hold};
               state_in    = is_last ? ST_FLUSH : ST_RD;
               slot_in     = slot_ff + 2'd1;
            end
         end
         ST_STOP: begin
            emit_req.push = 1'b1;
            emit_req.wr   = '{chan: info.chan, kind: sss_pkg::KIND_VOL,
                              value: 10'(sss_pkg::SILENT)};
            if (emit_ok) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = '{active: 1'b0, pos: info.len, hold: 8'd0};
               state_in    = is_last ? ST_FLUSH : ST_STOP;
               slot_in     = slot_ff + 2'd1;
            end
         end
         ST_FLUSH: begin
            emit_req.flush = 1'b1;
            if (emit_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         noise_ff <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         noise_ff <= noise_in;
      end
   end

   always_ff @(posedge clock) begin
      rom_ff <= rom_in;
   end

   `SSS_ASSERT_IMP(a_no_rd_wr_overlap, mem_rd_en, !mem_wr_en)
   `SSS_ASSERT_IMP(a_push_in_emit_state, emit_req.push, (state_ff == ST_START) || (state_ff == ST_EVAL) || (state_ff == ST_TONE) || (state_ff == ST_VOL) || (state_ff == ST_STOP))

endmodule

// ===== rtl/sound_step_sequencer.sv =====
// Top level of the sound step sequencer: command channel in, chip write words out.
// Sequence: a start writes the slot state (and, for the noise sound, a noise word); a stop-all
// silences each slot in turn; a tick reads and steps each slot in turn; each run ends in a flush.
// Throughput: one command at a time, next command taken the cycle after the run closes.
// Reset: synchronous, active high; all slots idle, noise setting 0, no words pending.
// The slot memory needs no clearing pass: per-entry valid bits cover it.

module sound_step_sequencer #(
   parameter int SOUND_SLOTS    = sss_pkg::SOUND_SLOTS_DEF,
   parameter int STEP_ROM_DEPTH = sss_pkg::STEP_ROM_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sss_req_if.sink    req_ch,
   sss_rsp_if.source  rsp_ch,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data
);

   // only the four defined sounds can ever play; extra slots do not exist
   localparam int LIVE_SLOTS = (SOUND_SLOTS < sss_pkg::DEFINED_SOUNDS) ?
                               SOUND_SLOTS : sss_pkg::DEFINED_SOUNDS;
   localparam int LIVE_AW    = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1;
   localparam int ROM_DAW    = $clog2(STEP_ROM_DEPTH);

   logic                   mem_rd_en;
   logic [LIVE_AW-1:0]     mem_rd_addr;
   sss_pkg::slot_type      mem_rd_data;
   logic                   mem_wr_en;
   logic [LIVE_AW-1:0]     mem_wr_addr;
   sss_pkg::slot_type      mem_wr_data;
   sss_pkg::emit_req_type  emit_req;
   logic                   emit_ok;

   // slot state: active flag, step position and hold count for each sound
   sss_slot_mem #(
      .DEPTH (LIVE_SLOTS),
      .AW    (LIVE_AW)
   ) u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // sequencer: decode the command, then walk the slots in order
   sss_ctrl #(
      .LIVE_SLOTS     (LIVE_SLOTS),
      .LIVE_AW        (LIVE_AW),
      .STEP_ROM_DEPTH (STEP_ROM_DEPTH),
      .ROM_DAW        (ROM_DAW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .emit_req    (emit_req),
      .emit_ok     (emit_ok)
   );

   // output side: hold back one word so the last of a run can be tagged,
   // then register it onto the result channel
   sss_emit u_emit (
      .clock  (clock),
      .reset  (reset),
      .req    (emit_req),
      .ok     (emit_ok),
      .rsp_ch (rsp_ch)
   );

endmodule
